### hdl/frustum_obb_cull_test_assert.svh
// Assertion macros for the frustum box cull test.
// Included by modules that check their own logic; no other dependencies.
`ifndef FRUSTUM_OBB_CULL_TEST_ASSERT_SVH
`define FRUSTUM_OBB_CULL_TEST_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on clk, held off while rst_n is low.
`define FOC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on clk, also during reset.
`define FOC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FOC_ASSERT(label, prop, msg)
`define FOC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### hdl/foc_pkg.sv
// Types and constants for the frustum box cull test.
// No dependencies; used by frustum_obb_cull_test.
package foc_pkg;

  localparam int NUM_PLANE_REGS = 6;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;

  localparam int COORD_W  = 20;  // Q12.8
  localparam int NORM_W   = 14;  // Q2.12
  localparam int OFFS_W   = 22;  // Q14.8
  localparam int PROD_W   = NORM_W + COORD_W;  // one normal times one coordinate
  localparam int DOT_W    = PROD_W + 2;        // three-term dot product, also distance
  localparam int MAG_W    = DOT_W - 1;         // magnitude of a dot product
  localparam int RAD_W    = MAG_W + 2;         // sum of three magnitudes
  localparam int CMP_W    = RAD_W + 2;         // signed compare width
  localparam int OFFS_SH  = 12;                // Q14.8 offset to 20 fraction bits

  // Plane register layout
  localparam int NX_LSB = 0;
  localparam int NY_LSB = 14;
  localparam int NZ_LSB = 28;
  localparam int D_LSB  = 42;

  localparam logic [1:0] REL_FRONT = 2'd0;
  localparam logic [1:0] REL_SPAN  = 2'd1;
  localparam logic [1:0] REL_BACK  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic signed [COORD_W-1:0] half_axis0_x;
    logic signed [COORD_W-1:0] half_axis0_y;
    logic signed [COORD_W-1:0] half_axis0_z;
    logic signed [COORD_W-1:0] half_axis1_x;
    logic signed [COORD_W-1:0] half_axis1_y;
    logic signed [COORD_W-1:0] half_axis1_z;
    logic signed [COORD_W-1:0] half_axis2_x;
    logic signed [COORD_W-1:0] half_axis2_y;
    logic signed [COORD_W-1:0] half_axis2_z;
  } box_req_t;

  typedef struct packed {
    logic       visible;
    logic [1:0] relation;
  } cull_res_t;

endpackage

### hdl/frustum_obb_cull_test.sv
// Frustum versus oriented-box cull test, top level.
// Depends on foc_pkg and frustum_obb_cull_test_assert.svh.
//
// Takes one box request per cycle while in_stall is low and returns one cull
// result per box. Stage 1 forms all normal-by-coordinate products for every
// plane, stage 2 the dot products, their magnitudes and the center distance,
// stage 3 the projected radius, stage 4 the compares and the combined visible
// flag and relation. Each stage has its own valid bit and moves when the stage
// after it is empty or moving, so a stall at the output fills the pipe before
// in_stall rises. The user must write plane registers on the cfg port only
// while no request is in flight; the block does not enforce this. Writes to
// an index beyond the six planes are dropped. Only the first PLANE_COUNT
// planes (left, right, top, bottom, near, far order) take part.
`include "frustum_obb_cull_test_assert.svh"

module frustum_obb_cull_test
  import foc_pkg::*;
#(
  parameter int PLANE_COUNT = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  box_req_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cull_res_t             out_data
);

  // Plane registers
  logic [CFG_DATA_W-1:0] plane_r [NUM_PLANE_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLANE_REGS; i++) plane_r[i] <= '0;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_PLANE_REGS))) begin
      plane_r[cfg_index] <= cfg_wdata;
    end
  end

  // Plane fields
  logic signed [NORM_W-1:0] nrm [PLANE_COUNT][3];
  logic signed [OFFS_W-1:0] offs [PLANE_COUNT];

  always_comb begin
    for (int k = 0; k < PLANE_COUNT; k++) begin
      nrm[k][0] = plane_r[k][NX_LSB +: NORM_W];
      nrm[k][1] = plane_r[k][NY_LSB +: NORM_W];
      nrm[k][2] = plane_r[k][NZ_LSB +: NORM_W];
      offs[k]   = plane_r[k][D_LSB +: OFFS_W];
    end
  end

  // Handshake chain
  logic [3:0] vld_r;
  logic [3:0] rdy;

  assign rdy[3]    = !vld_r[3] || !out_stall;
  assign rdy[2]    = !vld_r[2] || rdy[3];
  assign rdy[1]    = !vld_r[1] || rdy[2];
  assign rdy[0]    = !vld_r[0] || rdy[1];
  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      if (rdy[1]) vld_r[1] <= vld_r[0];
      if (rdy[2]) vld_r[2] <= vld_r[1];
      if (rdy[3]) vld_r[3] <= vld_r[2];
    end
  end

  // Stage 1: products
  logic signed [COORD_W-1:0] cen [3];
  logic signed [COORD_W-1:0] ax  [3][3];
  logic signed [PROD_W-1:0]  aprod_nxt [PLANE_COUNT][3][3];
  logic signed [PROD_W-1:0]  cprod_nxt [PLANE_COUNT][3];
  logic signed [PROD_W-1:0]  aprod_r   [PLANE_COUNT][3][3];
  logic signed [PROD_W-1:0]  cprod_r   [PLANE_COUNT][3];

  always_comb begin
    cen[0]   = in_data.center_x;
    cen[1]   = in_data.center_y;
    cen[2]   = in_data.center_z;
    ax[0][0] = in_data.half_axis0_x;
    ax[0][1] = in_data.half_axis0_y;
    ax[0][2] = in_data.half_axis0_z;
    ax[1][0] = in_data.half_axis1_x;
    ax[1][1] = in_data.half_axis1_y;
    ax[1][2] = in_data.half_axis1_z;
    ax[2][0] = in_data.half_axis2_x;
    ax[2][1] = in_data.half_axis2_y;
    ax[2][2] = in_data.half_axis2_z;
    for (int k = 0; k < PLANE_COUNT; k++) begin
      for (int c = 0; c < 3; c++) begin
        cprod_nxt[k][c] = PROD_W'(nrm[k][c]) * PROD_W'(cen[c]);
        for (int a = 0; a < 3; a++) begin
          aprod_nxt[k][a][c] = PROD_W'(nrm[k][c]) * PROD_W'(ax[a][c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      aprod_r <= aprod_nxt;
      cprod_r <= cprod_nxt;
    end
  end

  // Stage 2: dot products, magnitudes, center distance
  logic [MAG_W-1:0]        amag_nxt [PLANE_COUNT][3];
  logic signed [DOT_W-1:0] dist_nxt [PLANE_COUNT];
  logic [MAG_W-1:0]        amag_r   [PLANE_COUNT][3];
  logic signed [DOT_W-1:0] dist_r   [PLANE_COUNT];

  always_comb begin
    logic signed [DOT_W-1:0] dot;
    for (int k = 0; k < PLANE_COUNT; k++) begin
      for (int a = 0; a < 3; a++) begin
        dot = DOT_W'(aprod_r[k][a][0]) + DOT_W'(aprod_r[k][a][1])
            + DOT_W'(aprod_r[k][a][2]);
        amag_nxt[k][a] = dot[DOT_W-1] ? MAG_W'(-dot) : MAG_W'(dot);
      end
      // offset must stay static while requests are in flight; the block does not enforce this
      dist_nxt[k] = DOT_W'(cprod_r[k][0]) + DOT_W'(cprod_r[k][1]) + DOT_W'(cprod_r[k][2])
                  + (DOT_W'(offs[k]) <<< OFFS_SH);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      amag_r <= amag_nxt;
      dist_r <= dist_nxt;
    end
  end

  // Stage 3: projected radius
  logic [RAD_W-1:0]        rad_nxt [PLANE_COUNT];
  logic [RAD_W-1:0]        rad_r   [PLANE_COUNT];
  logic signed [DOT_W-1:0] sd_r    [PLANE_COUNT];

  always_comb begin
    for (int k = 0; k < PLANE_COUNT; k++) begin
      rad_nxt[k] = RAD_W'(amag_r[k][0]) + RAD_W'(amag_r[k][1]) + RAD_W'(amag_r[k][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      rad_r <= rad_nxt;
      sd_r  <= dist_r;
    end
  end

  // Stage 4: compares and result
  cull_res_t res_nxt;
  cull_res_t res_r;

  always_comb begin
    logic signed [CMP_W-1:0] s_ext;
    logic signed [CMP_W-1:0] r_pos;
    logic signed [CMP_W-1:0] r_neg;
    logic                    any_out;
    logic                    any_back;
    logic                    any_span;
    any_out  = 1'b0;
    any_back = 1'b0;
    any_span = 1'b0;
    for (int k = 0; k < PLANE_COUNT; k++) begin
      s_ext = CMP_W'(sd_r[k]);
      r_pos = $signed(CMP_W'(rad_r[k]));
      r_neg = -r_pos;
      if (s_ext <= r_neg) any_out  = 1'b1;
      if (s_ext <  r_neg) any_back = 1'b1;
      if (s_ext <= r_pos) any_span = 1'b1;
    end
    res_nxt.visible = !any_out;
    if (any_back) begin
      res_nxt.relation = REL_BACK;
    end else if (any_span) begin
      res_nxt.relation = REL_SPAN;
    end else begin
      res_nxt.relation = REL_FRONT;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      res_r <= res_nxt;
    end
  end

  assign out_data = res_r;

  // Checks
  `FOC_ASSERT(a_hidden_not_front, out_valid && !out_data.visible |-> out_data.relation != REL_FRONT, "hidden box reported in front")
  `FOC_ASSERT(a_back_is_hidden, out_valid && out_data.relation == REL_BACK |-> !out_data.visible, "box behind a plane reported visible")
  `FOC_ASSERT(a_stall_only_full, in_stall |-> vld_r == 4'hf, "input stalled with a pipeline bubble")
  `FOC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid right after reset")

endmodule
